// ===== rtl/aesc_pkg.sv =====
// ----------------------------------------------------------------------------
// aesc_pkg: shared types and constants for the encoder SPI command sequencer
// Holds the field widths, the opcode and result codes, and the encoder's
// command bytes.
// ----------------------------------------------------------------------------
package aesc_pkg;

  // Field widths
  localparam int OPCODE_W   = 2;
  localparam int DEVICE_W   = 3;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int POSITION_W = 12;
  localparam int NIBBLE_W   = 4;

  // Device count: default and the compare width that covers its whole range
  localparam int DEVICES_DEF = 8;
  localparam int DEV_CMP_W   = 7;

  // Poll limit after reset
  localparam logic [BYTE_W-1:0] POLL_LIMIT_RST = 8'd40;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_READ = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ZERO = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RX   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SEND      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ZERO_DONE = 2'd2;

  // Encoder command and echo bytes
  localparam logic [BYTE_W-1:0] CMD_READ  = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_ZERO  = 8'h70;
  localparam logic [BYTE_W-1:0] CMD_NOP   = 8'h00;
  localparam logic [BYTE_W-1:0] ECHO_WAIT = 8'hA5;
  localparam logic [BYTE_W-1:0] ECHO_ZERO = 8'h80;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_READ_WAIT,
    PH_READ_HI,
    PH_READ_LO,
    PH_ZERO_WAIT
  } phase_t;

endpackage

// ===== rtl/aesc_if.sv =====
// ----------------------------------------------------------------------------
// aesc_if: request and result channels of the encoder SPI command sequencer
// Valid/ready channels; a request or result moves when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface aesc_in_if
  import aesc_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [DEVICE_W-1:0] device;
  logic [BYTE_W-1:0]   rx_byte;

  modport source (output valid, output opcode, output device, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input device, input rx_byte, output ready);
endinterface

interface aesc_out_if
  import aesc_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [BYTE_W-1:0]     tx_byte;
  logic [DEVICE_W-1:0]   target;
  logic [POSITION_W-1:0] position;
  logic                  success;

  modport source (output valid, output kind, output tx_byte, output target,
                  output position, output success, input ready);
  modport sink   (input valid, input kind, input tx_byte, input target,
                  input position, input success, output ready);
endinterface

// ===== rtl/absolute_encoder_spi_command_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// absolute_encoder_spi_command_sequencer_top: encoder SPI command sequencer
// A request's result, if it has one, is registered and offered in the cycle after the request is taken.
// Throughput: one request per cycle while results are taken; the result register is the only stage.
// A request is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low): phase idle, counters clear, limit 40.
// ----------------------------------------------------------------------------
module absolute_encoder_spi_command_sequencer_top
  import aesc_pkg::*;
#(
  parameter int DEVICES = DEVICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  aesc_in_if.sink           in_if,
  aesc_out_if.source        out_if,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data
);

  localparam logic [DEV_CMP_W-1:0] DEV_LIMIT = DEV_CMP_W'(DEVICES);

  // Sequencer state
  phase_t                phase_r, phase_nxt;
  logic [BYTE_W-1:0]     poll_count_r, poll_count_nxt;
  logic [NIBBLE_W-1:0]   high_nibble_r, high_nibble_nxt;
  logic [DEVICE_W-1:0]   active_device_r, active_device_nxt;
  logic [BYTE_W-1:0]     poll_limit_r;

  // Result register
  logic                  out_valid_r;
  logic [KIND_W-1:0]     kind_r;
  logic [BYTE_W-1:0]     tx_byte_r;
  logic [DEVICE_W-1:0]   target_r;
  logic [POSITION_W-1:0] position_r;
  logic                  success_r;

  // Result of the current request
  logic                  res_valid;
  logic [KIND_W-1:0]     res_kind;
  logic [BYTE_W-1:0]     res_tx;
  logic [POSITION_W-1:0] res_pos;
  logic                  res_ok;

  logic in_fire;
  logic is_start;
  logic dev_ok;
  logic poll_left;

  // Take a request while the result slot is free or draining
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  assign dev_ok    = {{(DEV_CMP_W-DEVICE_W){1'b0}}, in_if.device} < DEV_LIMIT;
  assign is_start  = (in_if.opcode == OP_READ) || (in_if.opcode == OP_ZERO);
  assign poll_left = poll_count_r < poll_limit_r;

  // Next state
  always_comb begin
    phase_nxt         = phase_r;
    poll_count_nxt    = poll_count_r;
    high_nibble_nxt   = high_nibble_r;
    active_device_nxt = active_device_r;
    if (is_start) begin
      if (dev_ok) begin
        active_device_nxt = in_if.device;
        poll_count_nxt    = '0;
        high_nibble_nxt   = '0;
        phase_nxt         = (in_if.opcode == OP_READ) ? PH_READ_WAIT : PH_ZERO_WAIT;
      end
    end else if (in_if.opcode == OP_RX) begin
      case (phase_r)
        PH_READ_WAIT: begin
          if (in_if.rx_byte == CMD_READ) begin
            phase_nxt = PH_READ_HI;
          end else if (in_if.rx_byte == ECHO_WAIT && poll_left) begin
            poll_count_nxt = poll_count_r + 8'd1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_READ_HI: begin
          high_nibble_nxt = in_if.rx_byte[NIBBLE_W-1:0];
          phase_nxt       = PH_READ_LO;
        end
        PH_READ_LO: begin
          phase_nxt = PH_IDLE;
        end
        PH_ZERO_WAIT: begin
          if (in_if.rx_byte == ECHO_ZERO) begin
            phase_nxt = PH_IDLE;
          end else if (poll_left) begin
            poll_count_nxt = poll_count_r + 8'd1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Result for the request
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_SEND;
    res_tx    = CMD_NOP;
    res_pos   = '0;
    res_ok    = 1'b0;
    if (is_start) begin
      res_valid = dev_ok;
      res_tx    = (in_if.opcode == OP_READ) ? CMD_READ : CMD_ZERO;
    end else if (in_if.opcode == OP_RX) begin
      case (phase_r)
        PH_READ_WAIT: begin
          res_valid = 1'b1;
          if (!(in_if.rx_byte == CMD_READ) &&
              !(in_if.rx_byte == ECHO_WAIT && poll_left)) begin
            res_kind = KIND_READ_DONE;
          end
        end
        PH_READ_HI: begin
          res_valid = 1'b1;
        end
        PH_READ_LO: begin
          res_valid = 1'b1;
          res_kind  = KIND_READ_DONE;
          res_pos   = {high_nibble_r, in_if.rx_byte};
          res_ok    = 1'b1;
        end
        PH_ZERO_WAIT: begin
          res_valid = 1'b1;
          if (in_if.rx_byte == ECHO_ZERO) begin
            res_kind = KIND_ZERO_DONE;
            res_ok   = 1'b1;
          end else if (!poll_left) begin
            res_kind = KIND_ZERO_DONE;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // Advance state on each accepted request; load the poll limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      poll_count_r    <= '0;
      high_nibble_r   <= '0;
      active_device_r <= '0;
      poll_limit_r    <= POLL_LIMIT_RST;
    end else begin
      if (in_fire) begin
        phase_r         <= phase_nxt;
        poll_count_r    <= poll_count_nxt;
        high_nibble_r   <= high_nibble_nxt;
        active_device_r <= active_device_nxt;
      end
      if (cfg_wr_en) begin
        poll_limit_r <= cfg_wr_data;
      end
    end
  end

  // Hold the result until taken, refill on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r     <= res_kind;
      tx_byte_r  <= res_tx;
      target_r   <= active_device_nxt;
      position_r <= res_pos;
      success_r  <= res_ok;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.kind     = kind_r;
  assign out_if.tx_byte  = tx_byte_r;
  assign out_if.target   = target_r;
  assign out_if.position = position_r;
  assign out_if.success  = success_r;

  // A byte request never carries a success flag
  a_send_no_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_SEND |-> !success_r)
    else $error("send request flagged success");

  // A failed finish reports a zero position
  a_fail_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !success_r |-> position_r == '0)
    else $error("failed result carries a position");

  // A valid read start yields the read command on the next cycle
  a_read_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_if.opcode == OP_READ && dev_ok
      |=> out_valid_r && tx_byte_r == CMD_READ && phase_r == PH_READ_WAIT)
    else $error("read start did not issue read command");

  // Requests stall only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_valid_r)
    else $error("input stalled with empty result register");

endmodule

// ===== tb/absolute_encoder_spi_command_sequencer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the encoder SPI command sequencer
// Drives requests through the valid/ready request channel, predicts every
// result from a behavioral copy of the sequencer, and checks each result
// field by field in order. Covers position reads, set-zero commands, polling
// up to the limit, bad echoes, restarts and ignored requests, under random
// idling on both channels and several poll limits.
// ----------------------------------------------------------------------------
module absolute_encoder_spi_command_sequencer_top_tb;
  import aesc_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT = 21;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [BYTE_W-1:0]     tx_byte;
    logic [DEVICE_W-1:0]   target;
    logic [POSITION_W-1:0] position;
    logic                  success;
  } encoder_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [BYTE_W-1:0] cfg_wr_data;

  aesc_in_if  req_if ();
  aesc_out_if res_if ();

  absolute_encoder_spi_command_sequencer_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (req_if),
    .out_if      (res_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Sequencer state as predicted
  phase_t              phase_model;
  logic [BYTE_W-1:0]   poll_count_model;
  logic [NIBBLE_W-1:0] nibble_model;
  logic [DEVICE_W-1:0] device_model;
  logic [BYTE_W-1:0]   poll_limit_model;

  encoder_result_t pending_results[$];

  bit          idle_enable  = 1'b1;
  bit          stall_enable = 1'b1;
  int unsigned wait_budget  = 0;
  int unsigned errors       = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned reads_ok       = 0;
  int unsigned reads_failed   = 0;
  int unsigned zeros_ok       = 0;
  int unsigned zeros_failed   = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Compute the result a request causes and advance the predicted state
  function automatic bit predict_sequencer(input logic [OPCODE_W-1:0] op,
                                           input logic [DEVICE_W-1:0] dev,
                                           input logic [BYTE_W-1:0]   rx,
                                           output encoder_result_t    res);
    res = '0;
    res.kind    = KIND_SEND;
    res.tx_byte = CMD_NOP;
    if (op == OP_READ || op == OP_ZERO) begin
      if (int'(dev) >= DEVICES_DEF) return 1'b0;
      device_model     = dev;
      poll_count_model = '0;
      nibble_model     = '0;
      res.target       = dev;
      if (op == OP_READ) begin
        phase_model = PH_READ_WAIT;
        res.tx_byte = CMD_READ;
      end else begin
        phase_model = PH_ZERO_WAIT;
        res.tx_byte = CMD_ZERO;
      end
      return 1'b1;
    end
    if (op != OP_RX) return 1'b0;
    res.target = device_model;
    case (phase_model)
      PH_READ_WAIT: begin
        if (rx == CMD_READ) begin
          phase_model = PH_READ_HI;
        end else if (rx == ECHO_WAIT && poll_count_model < poll_limit_model) begin
          poll_count_model = poll_count_model + 1'b1;
        end else begin
          phase_model = PH_IDLE;
          res.kind    = KIND_READ_DONE;
        end
      end
      PH_READ_HI: begin
        nibble_model = rx[NIBBLE_W-1:0];
        phase_model  = PH_READ_LO;
      end
      PH_READ_LO: begin
        phase_model  = PH_IDLE;
        res.kind     = KIND_READ_DONE;
        res.position = {nibble_model, rx};
        res.success  = 1'b1;
      end
      PH_ZERO_WAIT: begin
        if (rx == ECHO_ZERO) begin
          phase_model = PH_IDLE;
          res.kind    = KIND_ZERO_DONE;
          res.success = 1'b1;
        end else if (poll_count_model < poll_limit_model) begin
          poll_count_model = poll_count_model + 1'b1;
        end else begin
          phase_model = PH_IDLE;
          res.kind    = KIND_ZERO_DONE;
        end
      end
      default: begin
        phase_model = PH_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // Drive one request, hold it until accepted, then queue its result
  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic [DEVICE_W-1:0] dev,
                              input logic [BYTE_W-1:0]   rx);
    encoder_result_t res;
    if (idle_enable && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.device  <= dev;
    req_if.rx_byte <= rx;
    do @(posedge clk); while (!req_if.ready);
    requests_sent++;
    if (predict_sequencer(op, dev, rx, res)) pending_results.push_back(res);
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_poll_limit(input logic [BYTE_W-1:0] limit);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en        <= 1'b0;
    poll_limit_model = limit;
  endtask

  // Pick the next request: mostly what the encoder would answer, some noise
  task automatic send_random_request();
    logic [OPCODE_W-1:0] op;
    logic [DEVICE_W-1:0] dev;
    logic [BYTE_W-1:0]   rx;
    bit                  noise;
    op    = OP_RX;
    dev   = DEVICE_W'($urandom_range(0, DEVICES_DEF - 1));
    rx    = BYTE_W'($urandom_range(0, 255));
    noise = ($urandom_range(0, 99) < 15);
    if (noise) begin
      op = OPCODE_W'($urandom_range(0, 3));
    end else begin
      case (phase_model)
        PH_IDLE: begin
          op = $urandom_range(0, 1) ? OP_ZERO : OP_READ;
        end
        PH_READ_WAIT: begin
          rx = (wait_budget > 0) ? ECHO_WAIT : CMD_READ;
        end
        PH_ZERO_WAIT: begin
          if (wait_budget == 0) rx = ECHO_ZERO;
          else if (rx == ECHO_ZERO) rx = CMD_NOP;
        end
        default: ;
      endcase
      if (op == OP_RX && wait_budget > 0 &&
          (phase_model == PH_READ_WAIT || phase_model == PH_ZERO_WAIT)) begin
        wait_budget--;
      end
    end
    // Plan how long the encoder keeps answering with wait bytes
    if (op == OP_READ || op == OP_ZERO) begin
      wait_budget = ($urandom_range(0, 7) == 0) ? int'(poll_limit_model) + 1
                                                 : $urandom_range(0, 4);
    end
    send_request(op, dev, rx);
  endtask

  task automatic run_random_phase(input logic [BYTE_W-1:0] limit,
                                  input int unsigned count);
    write_poll_limit(limit);
    repeat (count) send_random_request();
  endtask

  task automatic test_read_sequence();
    send_request(OP_READ, 3'd0, 8'h00);
    send_request(OP_RX, 3'd7, ECHO_WAIT);
    send_request(OP_RX, 3'd0, CMD_READ);
    send_request(OP_RX, 3'd0, 8'hFF);
    send_request(OP_RX, 3'd0, 8'hFF);
  endtask

  task automatic test_zero_sequence();
    send_request(OP_ZERO, 3'd7, 8'hFF);
    send_request(OP_RX, 3'd0, CMD_NOP);
    send_request(OP_RX, 3'd0, ECHO_WAIT);
    send_request(OP_RX, 3'd0, ECHO_ZERO);
  endtask

  // Bytes while idle and the unused opcode produce nothing
  task automatic test_ignored_requests();
    send_request(OP_RX, 3'd0, ECHO_ZERO);
    send_request(OP_UNUSED, 3'd7, 8'hFF);
  endtask

  task automatic test_bad_echo();
    send_request(OP_READ, 3'd5, 8'h00);
    send_request(OP_RX, 3'd0, 8'h33);
  endtask

  // A new command abandons the one in progress
  task automatic test_restart_while_busy();
    send_request(OP_READ, 3'd2, 8'h00);
    send_request(OP_RX, 3'd0, ECHO_WAIT);
    send_request(OP_ZERO, 3'd3, 8'h00);
    send_request(OP_RX, 3'd0, ECHO_ZERO);
  endtask

  task automatic test_poll_limit_edges();
    // With no polling allowed the first echo decides
    write_poll_limit(8'd0);
    send_request(OP_READ, 3'd4, 8'h00);
    send_request(OP_RX, 3'd0, ECHO_WAIT);
    send_request(OP_ZERO, 3'd6, 8'h00);
    send_request(OP_RX, 3'd0, CMD_NOP);
    write_poll_limit(8'd1);
    send_request(OP_READ, 3'd3, 8'h00);
    send_request(OP_RX, 3'd0, ECHO_WAIT);
    send_request(OP_RX, 3'd0, ECHO_WAIT);
    write_poll_limit(8'd255);
  endtask

  task automatic test_random_traffic();
    run_random_phase(POLL_LIMIT_RST, 200);
    run_random_phase(8'd1, 200);
    // Long stretch with both channels running flat out
    idle_enable  = 1'b0;
    stall_enable = 1'b0;
    run_random_phase(8'd3, 200);
    idle_enable  = 1'b1;
    stall_enable = 1'b1;
    run_random_phase(8'd255, 200);
    run_random_phase(BYTE_W'($urandom_range(2, 20)), 200);
    run_random_phase(8'd0, 200);
    run_random_phase(8'd7, 200);
  endtask

  // Randomly stall the result channel
  always @(posedge clk) begin
    res_if.ready <= (stall_enable && $urandom_range(0, 99) < IDLE_PCT) ? 1'b0 : 1'b1;
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    encoder_result_t exp_res;
    if (rst_n && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: kind %0d tx_byte %0h",
               res_if.kind, res_if.tx_byte);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res_if.kind !== exp_res.kind) begin
          $error("kind: expected %0d, got %0d", exp_res.kind, res_if.kind);
          errors++;
        end
        if (res_if.tx_byte !== exp_res.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", exp_res.tx_byte, res_if.tx_byte);
          errors++;
        end
        if (res_if.target !== exp_res.target) begin
          $error("target: expected %0d, got %0d", exp_res.target, res_if.target);
          errors++;
        end
        if (res_if.position !== exp_res.position) begin
          $error("position: expected %0h, got %0h", exp_res.position, res_if.position);
          errors++;
        end
        if (res_if.success !== exp_res.success) begin
          $error("success: expected %0d, got %0d", exp_res.success, res_if.success);
          errors++;
        end
        case (exp_res.kind)
          KIND_READ_DONE: if (exp_res.success) reads_ok++; else reads_failed++;
          KIND_ZERO_DONE: if (exp_res.success) zeros_ok++; else zeros_failed++;
          default: ;
        endcase
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.opcode  <= OP_RX;
    req_if.device  <= '0;
    req_if.rx_byte <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= POLL_LIMIT_RST;
    phase_model      = PH_IDLE;
    poll_count_model = '0;
    nibble_model     = '0;
    device_model     = '0;
    poll_limit_model = POLL_LIMIT_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_read_sequence();
    test_zero_sequence();
    test_ignored_requests();
    test_bad_echo();
    test_restart_while_busy();
    test_poll_limit_edges();
    test_random_traffic();
    drain_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests, checked %0d results over poll limits 0 to 255",
             requests_sent, results_seen);
    $display("Reads ok %0d, reads failed %0d, zeros ok %0d, zeros failed %0d",
             reads_ok, reads_failed, zeros_ok, zeros_failed);
    if (errors == 0) begin
      $display("absolute_encoder_spi_command_sequencer_top: match");
    end else begin
      $display("absolute_encoder_spi_command_sequencer_top: mismatch");
    end
    $finish;
  end

  // Give up if traffic stops moving
  initial begin
    #5000000;
    $display("absolute_encoder_spi_command_sequencer_top: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/aesc_pkg.sv
rtl/aesc_if.sv
rtl/absolute_encoder_spi_command_sequencer_top.sv
tb/absolute_encoder_spi_command_sequencer_top_tb.sv
